>>> design/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Field widths, stream packing and the command and status codes.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + LEN_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - LEN_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_REM_VAL = 3'd3,
        CMD_REM_AT  = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INDEX    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

endpackage

>>> design/ordered_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed 32-bit values kept contiguously in one RAM.
//
// Requests enter on the s_ channel: s_tuser carries the command, s_tdata the
// value and position. Each request gives exactly one response on the m_
// channel: s_tdata-style m_tdata holds the removed or read value and the new
// length, m_tuser the status.
// One request is in work at a time; s_tready is high while the engine idles.
// Each entry moved or searched takes one RAM access; moves use the single write port:
//   insert/append/prepend: shift entries from the tail down to position up one address, then write
//   remove at position:    shift the entries after position down one address
//   remove value:          scan from the head, then shift as for remove at position
//   read, errors:          no shifting
// The response sits in an output register; a new request is taken while it
// waits, and a stalled receiver holds the engine only when the next response
// is ready to be loaded. Reset empties the list; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ole_pkg::S_TDATA_W-1:0] s_tdata,  // item_value, position, zero pad
    input  logic [ole_pkg::CMD_W-1:0]    s_tuser,   // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ole_pkg::M_TDATA_W-1:0] m_tdata,  // result_value, length, zero pad
    output logic [ole_pkg::STATUS_W-1:0] m_tuser    // status
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int POS_W = ole_pkg::POS_W;
    localparam int LEN_W = ole_pkg::LEN_W;
    localparam int CMPW  = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        IDLE,
        INS_SHIFT,
        INS_PUT,
        SCAN,
        TAKE,
        DEL_SHIFT,
        READ_WAIT,
        RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                cur_reg, cur_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [ole_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [ole_pkg::VALUE_W-1:0]  res_reg, res_next;
    ole_pkg::status_t             st_reg, st_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ole_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [ole_pkg::STATUS_W-1:0] m_user_reg, m_user_next;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [ole_pkg::VALUE_W-1:0]  wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [ole_pkg::VALUE_W-1:0]  rd_data;

    logic [ole_pkg::VALUE_W-1:0]  in_value;
    logic [POS_W-1:0]             in_pos;
    logic [CMPW-1:0]              pos_ext;
    logic [CMPW-1:0]              cnt_ext;
    logic [CMPW-1:0]              ins_pos;
    logic [AW-1:0]                last_addr;
    logic                         full;
    logic                         at_last;

    assign in_value  = s_tdata[ole_pkg::VALUE_W-1:0];
    assign in_pos    = s_tdata[ole_pkg::VALUE_W +: POS_W];
    assign pos_ext   = CMPW'(in_pos);
    assign cnt_ext   = CMPW'(cnt_reg);
    assign last_addr = AW'(cnt_reg - CW'(1));
    assign full      = (cnt_reg == CW'(CAPACITY));
    assign at_last   = (cur_reg == last_addr);

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    ole_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = cur_reg;
        ins_pos      = pos_ext;

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    val_next   = in_value;
                    res_next   = '0;
                    st_next    = ole_pkg::STAT_OK;
                    state_next = RESP;
                    case (ole_pkg::cmd_t'(s_tuser))
                        ole_pkg::CMD_APPEND, ole_pkg::CMD_PREPEND,
                        ole_pkg::CMD_INSERT: begin
                            if (ole_pkg::cmd_t'(s_tuser) == ole_pkg::CMD_APPEND) begin
                                ins_pos = cnt_ext;
                            end else if (ole_pkg::cmd_t'(s_tuser) == ole_pkg::CMD_PREPEND) begin
                                ins_pos = '0;
                            end
                            if (ole_pkg::cmd_t'(s_tuser) == ole_pkg::CMD_INSERT &&
                                pos_ext > cnt_ext) begin
                                st_next = ole_pkg::STAT_INDEX;
                            end else if (full) begin
                                st_next = ole_pkg::STAT_FULL;
                            end else begin
                                pos_next = AW'(ins_pos);
                                if (cnt_ext > ins_pos) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = last_addr;
                                    cur_next   = last_addr;
                                    state_next = INS_SHIFT;
                                end else begin
                                    state_next = INS_PUT;
                                end
                            end
                        end
                        ole_pkg::CMD_REM_VAL: begin
                            if (cnt_reg == '0) begin
                                st_next = ole_pkg::STAT_NOTFOUND;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                cur_next   = '0;
                                state_next = SCAN;
                            end
                        end
                        ole_pkg::CMD_REM_AT, ole_pkg::CMD_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                st_next = ole_pkg::STAT_INDEX;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = AW'(in_pos);
                                cur_next = AW'(in_pos);
                                if (ole_pkg::cmd_t'(s_tuser) == ole_pkg::CMD_READ) begin
                                    state_next = READ_WAIT;
                                end else begin
                                    state_next = TAKE;
                                end
                            end
                        end
                        default: begin
                            state_next = RESP;
                        end
                    endcase
                end
            end
            INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = cur_reg + AW'(1);
                wr_data = rd_data;
                if (cur_reg == pos_reg) begin
                    state_next = INS_PUT;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg - AW'(1);
                    cur_next = cur_reg - AW'(1);
                end
            end
            INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = RESP;
            end
            SCAN, TAKE: begin
                if (state_reg == TAKE || rd_data == val_reg) begin
                    res_next = rd_data;
                    if (at_last) begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = RESP;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_reg + AW'(1);
                        cur_next   = cur_reg + AW'(1);
                        state_next = DEL_SHIFT;
                    end
                end else if (at_last) begin
                    st_next    = ole_pkg::STAT_NOTFOUND;
                    state_next = RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg + AW'(1);
                    cur_next = cur_reg + AW'(1);
                end
            end
            DEL_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = cur_reg - AW'(1);
                wr_data = rd_data;
                if (at_last) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg + AW'(1);
                    cur_next = cur_reg + AW'(1);
                end
            end
            READ_WAIT: begin
                res_next   = rd_data;
                state_next = RESP;
            end
            RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{ole_pkg::M_PAD_W{1'b0}}, LEN_W'(cnt_reg), res_reg};
                    m_user_next  = st_reg;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

>>> design/ole_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list entry store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ole_pkg::VALUE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ole_pkg::VALUE_W-1:0] rd_data
);

    logic [ole_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [ole_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
